// File: hw/rtl/pss_pkg.sv
// ============================================================================
// pss_pkg: shared definitions for the positional sequence store
// Request codes, front-to-back command format and stream field layout.
// ============================================================================
package pss_pkg;

    // Default sizes handed to the top level
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths of the stream channels
    localparam int ITEM_BITS    = 32;
    localparam int POS_BITS     = 6;
    localparam int REQ_BITS     = 2;
    localparam int S_TDATA_BITS = ((ITEM_BITS + POS_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 2;

    // Bit positions in m_tuser
    localparam int USER_EMPTY   = 0;
    localparam int USER_IGNORED = 1;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request codes on s_tuser
    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_DELETE     = 2'd2;

    // Operation codes of a queued command
    typedef logic [1:0] op_t;
    localparam op_t OP_PUSH_FRONT = 2'd0;
    localparam op_t OP_PUSH_BACK  = 2'd1;
    localparam op_t OP_DELETE     = 2'd2;
    localparam op_t OP_NOP        = 2'd3;

    // One classified request
    typedef struct packed {
        op_t                 op;
        logic [ITEM_BITS-1:0] value;
        logic [POS_BITS-1:0]  pos;
    } cmd_t;

endpackage

// File: hw/rtl/pss_front.sv
// ============================================================================
// pss_front: request intake
// Accepts stream items, decodes the request kind and forms a command.
// ============================================================================
module pss_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: item_value [31:0], position [37:32], zero pad above
    input  logic [pss_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [pss_pkg::REQ_BITS-1:0]      s_tuser,
    output logic                              push_valid,
    input  logic                              push_ready,
    output pss_pkg::cmd_t                     push_cmd
);

    pss_pkg::op_t op;

    // Decode the request kind; the unused code becomes a no-op
    always_comb begin
        unique case (s_tuser)
            pss_pkg::REQ_PUSH_FRONT: op = pss_pkg::OP_PUSH_FRONT;
            pss_pkg::REQ_PUSH_BACK:  op = pss_pkg::OP_PUSH_BACK;
            pss_pkg::REQ_DELETE:     op = pss_pkg::OP_DELETE;
            default:                 op = pss_pkg::OP_NOP;
        endcase
    end

    // Pass the item on whenever the queue has room
    assign s_tready       = push_ready;
    assign push_valid     = s_tvalid;
    assign push_cmd.op    = op;
    assign push_cmd.value = s_tdata[pss_pkg::ITEM_BITS-1:0];
    assign push_cmd.pos   = s_tdata[pss_pkg::ITEM_BITS +: pss_pkg::POS_BITS];

endmodule

// File: hw/rtl/pss_queue.sv
// ============================================================================
// pss_queue: command queue
// Short first-in first-out buffer between request intake and execution.
// ============================================================================
module pss_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  pss_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pss_pkg::cmd_t pop_cmd
);

    localparam int QIW = (pss_pkg::QUEUE_DEPTH > 1) ? $clog2(pss_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(pss_pkg::QUEUE_DEPTH + 1);
    localparam logic [QIW-1:0] LAST_PTR = QIW'(pss_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_CNT = QCW'(pss_pkg::QUEUE_DEPTH);

    pss_pkg::cmd_t  slot_reg [pss_pkg::QUEUE_DEPTH];
    logic [QIW-1:0] wr_ptr_reg;
    logic [QIW-1:0] rd_ptr_reg;
    logic [QCW-1:0] fill_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store an incoming command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + QIW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + QIW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QCW'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QCW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pss_back.sv
// ============================================================================
// pss_back: command execution and dump
// Ring store in one memory; runs pushes, shift-down deletes and the dump.
// ============================================================================
module pss_back #(
    parameter int CAPACITY   = pss_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = pss_pkg::DEF_VALUE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  pss_pkg::cmd_t                     cmd,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: entry_value [31:0]
    output logic [pss_pkg::ITEM_BITS-1:0]     m_tdata,
    // m_tlast: is_last
    output logic                              m_tlast,
    // m_tuser: is_empty [0], ignored [1]
    output logic [pss_pkg::M_TUSER_BITS-1:0]  m_tuser
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > pss_pkg::POS_BITS) ? CW : pss_pkg::POS_BITS;
    localparam int XW = (VALUE_BITS > pss_pkg::ITEM_BITS) ? VALUE_BITS : pss_pkg::ITEM_BITS;
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
    localparam logic [CW:0]   CAP_SUM   = (CW + 1)'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_DUMP  = 2'd2;

    // Ring slot of an offset from a base slot
    function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(off);
        if (s >= CAP_SUM) begin
            s = s - CAP_SUM;
        end
        return s[IW-1:0];
    endfunction

    // Next ring slot
    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + IW'(1);
    endfunction

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rdata_reg;

    logic [1:0]    state_reg,   state_next;
    logic [IW-1:0] front_reg,   front_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [CW-1:0] left_reg,    left_next;
    logic [IW-1:0] rd_slot_reg, rd_slot_next;
    logic [IW-1:0] wr_slot_reg, wr_slot_next;
    logic          pend_reg,    pend_next;
    logic          ign_reg,     ign_next;
    logic [CW-1:0] dcnt_reg,    dcnt_next;
    logic [IW-1:0] dslot_reg,   dslot_next;
    logic          rv_reg,      rv_next;
    logic          rlast_reg,   rlast_next;
    logic          rempty_reg,  rempty_next;

    logic                          ov_reg;
    logic [pss_pkg::ITEM_BITS-1:0] odata_reg;
    logic                          olast_reg;
    logic                          oempty_reg;
    logic                          oign_reg;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  move;
    logic                  issue_more;
    logic                  full;
    logic                  pos_ok;
    logic [CW-1:0]         pos_c;
    logic [IW-1:0]         del_slot;

    logic signed [pss_pkg::ITEM_BITS-1:0] item_s;
    logic [XW-1:0]                        item_wide;
    logic [VALUE_BITS-1:0]                fit_value;
    logic signed [VALUE_BITS-1:0]         rd_s;
    logic [XW-1:0]                        rd_wide;
    logic [pss_pkg::ITEM_BITS-1:0]        out_word;

    // Fit the pushed value to the store width and the stored value to the port
    assign item_s    = cmd.value;
    assign item_wide = XW'(item_s);
    assign fit_value = item_wide[VALUE_BITS-1:0];
    assign rd_s      = rdata_reg;
    assign rd_wide   = XW'(rd_s);
    assign out_word  = rd_wide[pss_pkg::ITEM_BITS-1:0];

    assign full     = (count_reg == CAP_CNT);
    assign pos_ok   = PW'(cmd.pos) < PW'(count_reg);
    assign pos_c    = CW'(cmd.pos);
    assign del_slot = slot_add(front_reg, pos_c);

    // Sequence control
    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        pend_next    = pend_reg;
        ign_next     = ign_reg;
        dcnt_next    = dcnt_reg;
        dslot_next   = dslot_reg;
        rv_next      = rv_reg;
        rlast_next   = rlast_reg;
        rempty_next  = rempty_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_slot_reg;
        mem_wdata    = rdata_reg;
        rd_en        = 1'b0;
        rd_addr      = rd_slot_reg;
        pop_ready    = (state_reg == S_IDLE);
        move         = rv_reg && (!ov_reg || m_tready);
        issue_more   = (count_reg == '0) ? (dcnt_reg == '0) : (dcnt_reg < count_reg);

        // Drain the read stage into the output register
        if (move) begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    ign_next   = 1'b0;
                    dcnt_next  = '0;
                    state_next = S_DUMP;
                    unique case (cmd.op)
                        pss_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                ign_next = 1'b1;
                            end else begin
                                front_next = (front_reg == '0) ? LAST_SLOT
                                                               : front_reg - IW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = front_next;
                                mem_wdata  = fit_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pss_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                ign_next = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot_add(front_reg, count_reg);
                                mem_wdata  = fit_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pss_pkg::OP_DELETE: begin
                            if (!pos_ok) begin
                                ign_next = 1'b1;
                            end else if (pos_c == '0) begin
                                front_next = slot_inc(front_reg);
                                count_next = count_reg - CW'(1);
                            end else begin
                                count_next   = count_reg - CW'(1);
                                wr_slot_next = del_slot;
                                rd_slot_next = slot_inc(del_slot);
                                left_next    = count_reg - pos_c - CW'(1);
                                pend_next    = 1'b0;
                                state_next   = S_SHIFT;
                            end
                        end
                        default: begin
                            ign_next = 1'b1;
                        end
                    endcase
                    dslot_next = front_next;
                end
            end
            S_SHIFT: begin
                // Read one entry ahead, write the previous read one slot down
                if (left_reg != '0) begin
                    rd_en        = 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                    left_next    = left_reg - CW'(1);
                end
                pend_next = (left_reg != '0);
                if (pend_reg) begin
                    mem_we       = 1'b1;
                    wr_slot_next = slot_inc(wr_slot_reg);
                end
                if ((left_reg == '0) && !pend_reg) begin
                    dslot_next = front_reg;
                    state_next = S_DUMP;
                end
            end
            S_DUMP: begin
                // Issue one read per free read stage, front to back
                if (issue_more && (!rv_reg || move)) begin
                    rd_en       = (count_reg != '0);
                    rd_addr     = dslot_reg;
                    dslot_next  = slot_inc(dslot_reg);
                    dcnt_next   = dcnt_reg + CW'(1);
                    rv_next     = 1'b1;
                    rlast_next  = (count_reg == '0) || (dcnt_reg + CW'(1) == count_reg);
                    rempty_next = (count_reg == '0);
                end
                if (!issue_more && (!rv_reg || move)) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            rd_slot_reg <= '0;
            wr_slot_reg <= '0;
            pend_reg    <= 1'b0;
            ign_reg     <= 1'b0;
            dcnt_reg    <= '0;
            dslot_reg   <= '0;
            rv_reg      <= 1'b0;
            rlast_reg   <= 1'b0;
            rempty_reg  <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            rd_slot_reg <= rd_slot_next;
            wr_slot_reg <= wr_slot_next;
            pend_reg    <= pend_next;
            ign_reg     <= ign_next;
            dcnt_reg    <= dcnt_next;
            dslot_reg   <= dslot_next;
            rv_reg      <= rv_next;
            rlast_reg   <= rlast_next;
            rempty_reg  <= rempty_next;
            if (move) begin
                ov_reg <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (move) begin
            odata_reg  <= rempty_reg ? '0 : out_word;
            olast_reg  <= rlast_reg;
            oempty_reg <= rempty_reg;
            oign_reg   <= ign_reg;
        end
    end

    assign m_tvalid                      = ov_reg;
    assign m_tdata                       = odata_reg;
    assign m_tlast                       = olast_reg;
    assign m_tuser[pss_pkg::USER_EMPTY]   = oempty_reg;
    assign m_tuser[pss_pkg::USER_IGNORED] = oign_reg;

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // The store is never written while it is being dumped
    a_no_write_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_IDLE || state_reg == S_SHIFT))
        else $error("store written during dump");

    // An empty result is always the last of its dump
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (rv_reg && rempty_reg) |-> rlast_reg)
        else $error("empty result not marked last");

    // A shift write always follows a shift read
    a_shift_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && pend_reg) |-> $past(rd_en))
        else $error("shift write without preceding read");

endmodule

// File: hw/rtl/positional_sequence_store.sv
// ============================================================================
// positional_sequence_store: bounded deque with delete at any position
// Keeps up to CAPACITY signed values; dumps the whole sequence per request.
// ============================================================================
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the request kind
//   (push front, push back, delete), s_tdata the value and the position.
//   After every request the m_ channel streams the sequence front to back,
//   one item per entry, m_tlast on the final one. An empty store gives one
//   item flagged empty in m_tuser; a request with no effect (push while
//   full, bad position, unused kind) sets the ignored flag on its dump.
// Timing:
//   A two-deep command queue takes items while the executor works. With the
//   block idle, the first result item of a request passes the queue slot,
//   the executor state, the read stage and the output register before it
//   shows on m_tvalid. The executor handles the request, then dumps one
//   item per cycle while m_tready stays high. A delete behind the front
//   entry first moves the N-p entries behind position p one slot down (N
//   entries left), reading each before writing it. The ring memory has a
//   single read port; one request is handled at a time.
// Reset and stall:
//   Reset empties the store at once; no clearing pass runs. When m_tready
//   is low the dump holds, the queue fills and s_tready drops.
// ============================================================================
module positional_sequence_store #(
    parameter int CAPACITY   = pss_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = pss_pkg::DEF_VALUE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: item_value [31:0], position [37:32], zero pad above
    input  logic [pss_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [pss_pkg::REQ_BITS-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: entry_value [31:0]
    output logic [pss_pkg::ITEM_BITS-1:0]     m_tdata,
    // m_tlast: is_last
    output logic                              m_tlast,
    // m_tuser: is_empty [0], ignored [1]
    output logic [pss_pkg::M_TUSER_BITS-1:0]  m_tuser
);

    logic          push_valid;
    logic          push_ready;
    pss_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    pss_pkg::cmd_t pop_cmd;

    // Classify requests
    pss_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Buffer commands between intake and execution
    pss_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute commands and dump the sequence
    pss_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
